// File: rtl/bayer_bilinear_demosaic_unit_macros.svh
// Assertion macros for the Bayer demosaic unit.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef BAYER_BILINEAR_DEMOSAIC_UNIT_MACROS_SVH
`define BAYER_BILINEAR_DEMOSAIC_UNIT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define BBD_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define BBD_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bbd_pkg.sv
// Shared types and constants of the Bayer demosaic unit.
// Used by the top level, bbd_frame_ctrl, bbd_rgb_interp and the testbench; depends on nothing.
package bbd_pkg;

	typedef enum logic [1:0] {
		REG_BAYER_PHASE  = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2,
		REG_ROW_PADDING  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		RES_MAIN        = 2'd0,
		RES_RIGHT       = 2'd1,
		RES_LOWER       = 2'd2,
		RES_LOWER_RIGHT = 2'd3
	} res_kind_t;

	localparam logic [1:0]  PHASE_RESET   = 2'd0;
	localparam logic [12:0] WIDTH_RESET   = 13'd640;
	localparam logic [15:0] HEIGHT_RESET  = 16'd480;
	localparam logic [11:0] PADDING_RESET = 12'd0;

	localparam logic [14:0] LUMA_R     = 15'd9798;
	localparam logic [14:0] LUMA_G     = 15'd19234;
	localparam logic [14:0] LUMA_B     = 15'd3736;
	localparam logic [22:0] LUMA_ROUND = 23'd16384;

	typedef logic [2:0][2:0][7:0] win_t;

	typedef struct packed {
		logic [1:0]  bayer_phase;
		logic [12:0] image_width;
		logic [15:0] image_height;
		logic [11:0] row_padding;
	} cfg_t;

	typedef struct packed {
		logic emit;
		logic last_col;
		logic last_row;
		logic top_mir;
		logic left_mir;
		logic y0;
		logic x0;
	} pix_ctrl_t;

	typedef struct packed {
		res_kind_t kind;
		logic      top_mir;
		logic      left_mir;
		logic      y0;
		logic      x0;
		logic      run_last;
	} res_issue_t;

endpackage

// File: rtl/bbd_stream_ifs.sv
// Stream interfaces of the Bayer demosaic unit: raw bytes in, pixels out.
// Depends on nothing.
interface bbd_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_byte;

	modport source (output valid, raw_byte, input ready);
	modport sink (input valid, raw_byte, output ready);
endinterface

interface bbd_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] grey;
	logic       row_end;
	logic       frame_end;
	logic       run_last;

	modport source (output valid, red, green, blue, grey, row_end, frame_end, run_last,
		input ready);
	modport sink (input valid, red, green, blue, grey, row_end, frame_end, run_last,
		output ready);
endinterface

// File: rtl/bayer_bilinear_demosaic_unit.sv
// Top level of the Bayer demosaic unit: register port, window and result sequencer.
// Depends on bbd_pkg, the stream interfaces, bbd_line_store, bbd_frame_ctrl and
// bbd_rgb_interp, and on the assertion macro header.
//
//   Channel   Direction  Transaction
//   raw_in    sink       one raw byte of the frame, pixel or padding
//   rgb_out   source     one demosaiced pixel with grey and end flags
//   apb       slave      one register write or read, ready at once
//
// The unit takes one raw byte per cycle unless the pipeline holds it; each byte gives
// at most one pixel per cycle, so a byte closing a row after the first gives two pixels,
// a byte of the last row two, and the frame's last byte four, while the input waits.
// A result leaves through the line store read, the window, the interpolation stage and
// the output register, in that order.
// Reset clears the counters, the window and the registers; the line stores are
// not cleared and are written during the first two rows.
// A stalled output backs up through the pipeline and holds the input.
`include "bayer_bilinear_demosaic_unit_macros.svh"

module bayer_bilinear_demosaic_unit #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	bbd_raw_if.sink     raw_in,
	bbd_pix_if.source   rgb_out
);

	localparam int AW = $clog2(MAX_WIDTH);

	bbd_pkg::cfg_t      cfg_q;
	bbd_pkg::reg_idx_t  reg_idx;

	logic               accept;
	logic               is_pixel;
	logic [AW-1:0]      col_addr;
	bbd_pkg::pix_ctrl_t pix_ctrl;

	logic               s1_valid_q;
	logic [7:0]         raw_s1;
	logic [AW-1:0]      col_s1;
	bbd_pkg::pix_ctrl_t ctrl_s1;
	logic               s1_fire;
	logic [15:0]        line_rd;
	logic [7:0]         above_px;
	logic [7:0]         middle_px;

	bbd_pkg::win_t      win_q;
	bbd_pkg::win_t      win_n;

	logic               s2_valid_q;
	bbd_pkg::pix_ctrl_t s2_ctrl_q;
	bbd_pkg::res_kind_t kind_q;
	bbd_pkg::res_kind_t kind_next;
	logic               kind_last;
	logic               s2_free;
	logic               issue_ready;
	logic               issue_fire;
	bbd_pkg::res_issue_t issue;

	assign pready  = 1'b1;
	assign reg_idx = bbd_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bayer_phase  <= bbd_pkg::PHASE_RESET;
			cfg_q.image_width  <= bbd_pkg::WIDTH_RESET;
			cfg_q.image_height <= bbd_pkg::HEIGHT_RESET;
			cfg_q.row_padding  <= bbd_pkg::PADDING_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				bbd_pkg::REG_BAYER_PHASE: cfg_q.bayer_phase <= pwdata[1:0];
				bbd_pkg::REG_IMAGE_WIDTH: cfg_q.image_width <= pwdata[12:0];
				bbd_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[15:0];
				bbd_pkg::REG_ROW_PADDING: cfg_q.row_padding <= pwdata[11:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bbd_pkg::REG_BAYER_PHASE: prdata = 32'(cfg_q.bayer_phase);
			bbd_pkg::REG_IMAGE_WIDTH: prdata = 32'(cfg_q.image_width);
			bbd_pkg::REG_IMAGE_HEIGHT: prdata = 32'(cfg_q.image_height);
			bbd_pkg::REG_ROW_PADDING: prdata = 32'(cfg_q.row_padding);
			default: prdata = '0;
		endcase
	end

	assign s1_fire      = s1_valid_q && s2_free;
	assign raw_in.ready = !s1_valid_q || s1_fire;
	assign accept       = raw_in.valid && raw_in.ready;

	bbd_frame_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_frame_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cfg     (cfg_q),
		.is_pixel(is_pixel),
		.col_addr(col_addr),
		.ctrl    (pix_ctrl)
	);

	bbd_line_store #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept && is_pixel),
		.rd_addr(col_addr),
		.wr_en  (s1_fire),
		.wr_addr(col_s1),
		.wr_data({middle_px, raw_s1}),
		.rd_data(line_rd)
	);

	assign above_px  = line_rd[15:8];
	assign middle_px = line_rd[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (raw_in.ready) begin
			s1_valid_q <= accept && is_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_pixel) begin
			raw_s1  <= raw_in.raw_byte;
			col_s1  <= col_addr;
			ctrl_s1 <= pix_ctrl;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_n[r][0] = win_q[r][1];
			win_n[r][1] = win_q[r][2];
		end
		win_n[0][2] = above_px;
		win_n[1][2] = middle_px;
		win_n[2][2] = raw_s1;
	end

	// The window only moves once the previous byte has issued all its results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_fire) begin
			win_q <= win_n;
		end
	end

	always_comb begin
		case (kind_q)
			bbd_pkg::RES_MAIN: begin
				kind_next = s2_ctrl_q.last_col ? bbd_pkg::RES_RIGHT : bbd_pkg::RES_LOWER;
				kind_last = !s2_ctrl_q.last_col && !s2_ctrl_q.last_row;
			end
			bbd_pkg::RES_RIGHT: begin
				kind_next = bbd_pkg::RES_LOWER;
				kind_last = !s2_ctrl_q.last_row;
			end
			bbd_pkg::RES_LOWER: begin
				kind_next = bbd_pkg::RES_LOWER_RIGHT;
				kind_last = !s2_ctrl_q.last_col;
			end
			default: begin
				kind_next = bbd_pkg::RES_MAIN;
				kind_last = 1'b1;
			end
		endcase
	end

	assign issue_fire = s2_valid_q && issue_ready;
	assign s2_free    = !s2_valid_q || (issue_fire && kind_last);

	always_comb begin
		issue.kind     = kind_q;
		issue.top_mir  = s2_ctrl_q.top_mir;
		issue.left_mir = s2_ctrl_q.left_mir;
		issue.y0       = s2_ctrl_q.y0;
		issue.x0       = s2_ctrl_q.x0;
		issue.run_last = kind_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			kind_q     <= bbd_pkg::RES_MAIN;
		end else if (s1_fire) begin
			s2_valid_q <= ctrl_s1.emit;
			kind_q     <= bbd_pkg::RES_MAIN;
		end else if (issue_fire) begin
			s2_valid_q <= !kind_last;
			kind_q     <= kind_next;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			s2_ctrl_q <= ctrl_s1;
		end
	end

	bbd_rgb_interp u_rgb_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue_valid(s2_valid_q),
		.issue_ready(issue_ready),
		.issue      (issue),
		.win        (win_q),
		.bayer_phase(cfg_q.bayer_phase),
		.pix        (rgb_out)
	);

	`BBD_ASSERT_IMPLIES(a_corner_result_only_at_corner, s2_valid_q && (kind_q == bbd_pkg::RES_LOWER_RIGHT), s2_ctrl_q.last_row && s2_ctrl_q.last_col, "Lower right result issued away from the frame corner.")
	`BBD_ASSERT_IMPLIES(a_frame_end_closes_row, rgb_out.valid && rgb_out.frame_end, rgb_out.row_end && rgb_out.run_last, "Frame end without row end and run end.")
	`BBD_ASSERT_NEXT(a_emitting_byte_reaches_sequencer, s1_fire && ctrl_s1.emit, s2_valid_q && (kind_q == bbd_pkg::RES_MAIN), "Emitting pixel did not start its results.")

endmodule

// File: rtl/bbd_line_store.sv
// Line store holding the two previous rows, one 16-bit word per column.
// Synchronous memory whose read data is registered; depends on nothing.
module bbd_line_store #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  logic [15:0]                  wr_data,
	output logic [15:0]                  rd_data
);

	logic [15:0] mem [MAX_WIDTH];
	logic [15:0] mem_rd_q;
	logic [15:0] fwd_data_q;
	logic        fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	// A read that meets a write to the same column takes the new word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : mem_rd_q;

endmodule

// File: rtl/bbd_frame_ctrl.sv
// Column, row and padding counters that classify each raw byte.
// Depends on bbd_pkg for the register and control types.
module bbd_frame_ctrl #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  bbd_pkg::cfg_t                cfg,
	output logic                         is_pixel,
	output logic [$clog2(MAX_WIDTH)-1:0] col_addr,
	output bbd_pkg::pix_ctrl_t           ctrl
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int WW = (CW > 13) ? CW : 13;

	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	logic [11:0]   pad_q;

	logic [WW-1:0] width_ext;
	logic [CW-1:0] width_eff;
	logic [15:0]   height_eff;
	logic [CW-1:0] col_inc;
	logic [12:0]   pad_inc;
	logic [16:0]   row_inc;
	logic [15:0]   row_next;
	logic          row_done;

	always_comb begin
		width_ext = WW'(cfg.image_width);
		if (width_ext < WW'(2)) begin
			width_eff = CW'(2);
		end else if (width_ext > WW'(MAX_WIDTH)) begin
			width_eff = CW'(MAX_WIDTH);
		end else begin
			width_eff = width_ext[CW-1:0];
		end
		height_eff = (cfg.image_height < 16'd2) ? 16'd2 : cfg.image_height;
	end

	assign is_pixel = col_q < width_eff;
	assign col_addr = col_q[AW-1:0];
	assign col_inc  = col_q + CW'(1);
	assign pad_inc  = {1'b0, pad_q} + 13'd1;
	assign row_inc  = {1'b0, row_q} + 17'd1;
	assign row_next = (row_inc >= {1'b0, height_eff}) ? 16'd0 : row_inc[15:0];

	always_comb begin
		if (is_pixel) begin
			row_done = (col_inc == width_eff) && (cfg.row_padding == 12'd0);
		end else begin
			row_done = pad_inc >= {1'b0, cfg.row_padding};
		end
	end

	always_comb begin
		ctrl.emit     = (row_q != 16'd0) && (col_q != CW'(0));
		ctrl.last_col = col_q == (width_eff - CW'(1));
		ctrl.last_row = row_q == (height_eff - 16'd1);
		ctrl.top_mir  = row_q == 16'd1;
		ctrl.left_mir = col_q == CW'(1);
		ctrl.y0       = row_q[0];
		ctrl.x0       = col_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pad_q <= '0;
		end else if (accept) begin
			if (row_done) begin
				col_q <= '0;
				pad_q <= '0;
				row_q <= row_next;
			end else if (is_pixel) begin
				col_q <= col_inc;
			end else begin
				pad_q <= pad_inc[11:0];
			end
		end
	end

endmodule

// File: rtl/bbd_rgb_interp.sv
// Bilinear colour interpolation, luma and the output register of the unit.
// Depends on bbd_pkg and the bbd_pix_if stream interface.
module bbd_rgb_interp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                issue_valid,
	output logic                issue_ready,
	input  bbd_pkg::res_issue_t issue,
	input  bbd_pkg::win_t       win,
	input  logic [1:0]          bayer_phase,
	bbd_pix_if.source           pix
);

	logic [1:0] kind_bits;
	logic       py0;
	logic       px0;
	logic       redrow;
	logic       isgreen;
	logic [1:0] ti, mi, bi, li, ci, ri;
	logic [8:0] h_sum, v_sum;
	logic [9:0] cross_sum, diag_sum;
	logic [7:0] h_avg, v_avg, cross_avg, diag_avg, own;
	logic [7:0] red_n, green_n, blue_n;

	logic       s3_valid_q;
	logic [7:0] red_s3, green_s3, blue_s3;
	logic       row_end_s3, frame_end_s3, run_last_s3;
	logic [22:0] luma_sum;

	logic       out_valid_q;
	logic [7:0] red_q, green_q, blue_q, grey_q;
	logic       row_end_q, frame_end_q, run_last_q;
	logic       en_out;

	always_comb begin
		kind_bits = issue.kind;
		py0 = kind_bits[1] ? issue.y0 : ~issue.y0;
		px0 = kind_bits[0] ? issue.x0 : ~issue.x0;
		redrow  = ~bayer_phase[0] ^ py0;
		isgreen = bayer_phase[1] ^ py0 ^ px0;

		// The lower row mirrors downward and the right column mirrors rightward.
		ti = kind_bits[1] ? 2'd1 : (issue.top_mir ? 2'd2 : 2'd0);
		mi = kind_bits[1] ? 2'd2 : 2'd1;
		bi = kind_bits[1] ? 2'd1 : 2'd2;
		li = kind_bits[0] ? 2'd1 : (issue.left_mir ? 2'd2 : 2'd0);
		ci = kind_bits[0] ? 2'd2 : 2'd1;
		ri = kind_bits[0] ? 2'd1 : 2'd2;

		h_sum = {1'b0, win[mi][li]} + {1'b0, win[mi][ri]} + 9'd1;
		v_sum = {1'b0, win[ti][ci]} + {1'b0, win[bi][ci]} + 9'd1;
		cross_sum = {2'b00, win[ti][ci]} + {2'b00, win[bi][ci]} + {2'b00, win[mi][li]}
			+ {2'b00, win[mi][ri]} + 10'd2;
		diag_sum = {2'b00, win[ti][li]} + {2'b00, win[ti][ri]} + {2'b00, win[bi][li]}
			+ {2'b00, win[bi][ri]} + 10'd2;
		h_avg     = h_sum[8:1];
		v_avg     = v_sum[8:1];
		cross_avg = cross_sum[9:2];
		diag_avg  = diag_sum[9:2];
		own       = win[mi][ci];

		if (isgreen) begin
			green_n = own;
			red_n   = redrow ? h_avg : v_avg;
			blue_n  = redrow ? v_avg : h_avg;
		end else begin
			green_n = cross_avg;
			red_n   = redrow ? own : diag_avg;
			blue_n  = redrow ? diag_avg : own;
		end
	end

	assign en_out      = !out_valid_q || pix.ready;
	assign issue_ready = !s3_valid_q || en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid_q <= 1'b0;
		end else if (issue_ready) begin
			s3_valid_q <= issue_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (issue_valid && issue_ready) begin
			red_s3       <= red_n;
			green_s3     <= green_n;
			blue_s3      <= blue_n;
			row_end_s3   <= kind_bits[0];
			frame_end_s3 <= issue.kind == bbd_pkg::RES_LOWER_RIGHT;
			run_last_s3  <= issue.run_last;
		end
	end

	assign luma_sum = 23'(bbd_pkg::LUMA_R * red_s3) + 23'(bbd_pkg::LUMA_G * green_s3)
		+ 23'(bbd_pkg::LUMA_B * blue_s3) + bbd_pkg::LUMA_ROUND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= s3_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_valid_q && en_out) begin
			red_q       <= red_s3;
			green_q     <= green_s3;
			blue_q      <= blue_s3;
			grey_q      <= luma_sum[22:15];
			row_end_q   <= row_end_s3;
			frame_end_q <= frame_end_s3;
			run_last_q  <= run_last_s3;
		end
	end

	assign pix.valid     = out_valid_q;
	assign pix.red       = red_q;
	assign pix.green     = green_q;
	assign pix.blue      = blue_q;
	assign pix.grey      = grey_q;
	assign pix.row_end   = row_end_q;
	assign pix.frame_end = frame_end_q;
	assign pix.run_last  = run_last_q;

endmodule

// File: verif/bbd_demosaic_checker.sv
// Passive checker for the Bayer demosaic unit: follows register writes, predicts each pixel
// from the accepted raw bytes and compares it with what the unit emits.
// Depends on bbd_pkg and the stream interfaces bbd_raw_if and bbd_pix_if.
module bbd_demosaic_checker
	import bbd_pkg::*;
#(
	parameter int MAX_W = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	bbd_raw_if          raw_mon,
	bbd_pix_if          pix_mon,
	output int          mismatches,
	output int          outstanding,
	output int          checked
);

	localparam int LUMA_KR    = 9798;
	localparam int LUMA_KG    = 19234;
	localparam int LUMA_KB    = 3736;
	localparam int LUMA_HALF  = 16384;
	localparam int LUMA_SHIFT = 15;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] grey;
		logic       row_end;
		logic       frame_end;
		logic       run_last;
	} pixel_t;

	logic [1:0]  phase_q;
	logic [12:0] width_q;
	logic [15:0] height_q;
	logic [11:0] padding_q;

	logic [7:0] above_row [MAX_W];
	logic [7:0] middle_row [MAX_W];
	logic [7:0] win [3][3];
	int         col_cnt;
	int         row_cnt;
	int         pad_cnt;

	pixel_t expected_px [$];
	pixel_t want;

	function automatic pixel_t shade(int t, int m, int b, int l, int c, int r,
			int py, int px, logic re, logic fe);
		logic   green_row, red_row, green_site;
		int     h, v, rv, gv, bv, luma;
		pixel_t p;
		green_row  = phase_q[1] ^ py[0];
		red_row    = ~phase_q[0] ^ py[0];
		green_site = green_row ^ px[0];
		if (green_site) begin
			h  = (win[m][l] + win[m][r] + 1) >> 1;
			v  = (win[t][c] + win[b][c] + 1) >> 1;
			gv = win[m][c];
			rv = red_row ? h : v;
			bv = red_row ? v : h;
		end else begin
			h  = (win[t][c] + win[b][c] + win[m][l] + win[m][r] + 2) >> 2;
			v  = (win[t][l] + win[t][r] + win[b][l] + win[b][r] + 2) >> 2;
			gv = h;
			rv = red_row ? int'(win[m][c]) : v;
			bv = red_row ? v : int'(win[m][c]);
		end
		luma = (LUMA_KR * rv + LUMA_KG * gv + LUMA_KB * bv + LUMA_HALF) >> LUMA_SHIFT;
		p.red       = rv[7:0];
		p.green     = gv[7:0];
		p.blue      = bv[7:0];
		p.grey      = luma[7:0];
		p.row_end   = re;
		p.frame_end = fe;
		p.run_last  = 1'b0;
		return p;
	endfunction

	function automatic void absorb_byte(logic [7:0] raw);
		int         w, h, x, y, top, left, n;
		logic [7:0] a, mm;
		logic       last_col, row_done;
		pixel_t     res [4];
		w = width_q;
		if (w < 2) w = 2;
		if (w > MAX_W) w = MAX_W;
		h = (height_q < 2) ? 2 : height_q;
		n = 0;
		row_done = 1'b0;
		if (col_cnt < w) begin
			x = col_cnt;
			y = row_cnt;
			a = above_row[x];
			mm = middle_row[x];
			above_row[x] = mm;
			middle_row[x] = raw;
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = a;
			win[1][2] = mm;
			win[2][2] = raw;
			col_cnt = x + 1;
			if (y >= 1 && x >= 1) begin
				top = (y == 1) ? 2 : 0;
				left = (x == 1) ? 2 : 0;
				last_col = (x == w - 1);
				res[n] = shade(top, 1, 2, left, 1, 2, y - 1, x - 1, 1'b0, 1'b0);
				n++;
				if (last_col) begin
					res[n] = shade(top, 1, 2, 1, 2, 1, y - 1, x, 1'b1, 1'b0);
					n++;
				end
				if (y == h - 1) begin
					res[n] = shade(1, 2, 1, left, 1, 2, y, x - 1, 1'b0, 1'b0);
					n++;
					if (last_col) begin
						res[n] = shade(1, 2, 1, 1, 2, 1, y, x, 1'b1, 1'b1);
						n++;
					end
				end
			end
			if (col_cnt == w && padding_q == 0) row_done = 1'b1;
		end else begin
			pad_cnt++;
			if (pad_cnt >= padding_q) row_done = 1'b1;
		end
		if (row_done) begin
			col_cnt = 0;
			pad_cnt = 0;
			row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
		end
		if (n > 0) res[n - 1].run_last = 1'b1;
		for (int i = 0; i < n; i++) expected_px.push_back(res[i]);
	endfunction

	function automatic void match_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q = PHASE_RESET;
			width_q = WIDTH_RESET;
			height_q = HEIGHT_RESET;
			padding_q = PADDING_RESET;
			for (int i = 0; i < MAX_W; i++) begin
				above_row[i] = '0;
				middle_row[i] = '0;
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) win[i][j] = '0;
			end
			col_cnt = 0;
			row_cnt = 0;
			pad_cnt = 0;
			expected_px.delete();
			mismatches = 0;
			checked = 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_BAYER_PHASE:  phase_q = pwdata[1:0];
					REG_IMAGE_WIDTH:  width_q = pwdata[12:0];
					REG_IMAGE_HEIGHT: height_q = pwdata[15:0];
					REG_ROW_PADDING:  padding_q = pwdata[11:0];
					default: ;
				endcase
			end
			if (raw_mon.valid && raw_mon.ready) absorb_byte(raw_mon.raw_byte);
			if (pix_mon.valid && pix_mon.ready) begin
				if (expected_px.size() == 0) begin
					$error("Pixel transaction arrived with no pixel expected.");
					mismatches++;
				end else begin
					want = expected_px.pop_front();
					match_field("red", want.red, pix_mon.red);
					match_field("green", want.green, pix_mon.green);
					match_field("blue", want.blue, pix_mon.blue);
					match_field("grey", want.grey, pix_mon.grey);
					match_field("row_end", {7'd0, want.row_end}, {7'd0, pix_mon.row_end});
					match_field("frame_end", {7'd0, want.frame_end}, {7'd0, pix_mon.frame_end});
					match_field("run_last", {7'd0, want.run_last}, {7'd0, pix_mon.run_last});
					checked++;
				end
			end
			outstanding <= expected_px.size();
		end
	end

endmodule

// File: verif/tb_top.sv
// Testbench top for the Bayer demosaic unit: clock, reset, register writes, raw byte
// stimulus and output stalls; the verdict uses the counts of bbd_demosaic_checker.
// Depends on bbd_pkg, the stream interfaces, the unit and the checker.
module tb_top;
	import bbd_pkg::*;

	localparam int DRAIN_CYCLES      = 16;
	localparam int LONG_STALL_CYCLES = 300;
	localparam int RANDOM_PER_PHASE  = 6;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int outstanding;
	int checked;
	int pixel_bytes;
	int padding_bytes;
	int send_idle_pct;
	int recv_idle_pct;
	bit long_stall_due;

	bbd_raw_if raw_ch ();
	bbd_pix_if pix_ch ();

	bayer_bilinear_demosaic_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.raw_in  (raw_ch),
		.rgb_out (pix_ch)
	);

	bbd_demosaic_checker pixel_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.raw_mon     (raw_ch),
		.pix_mon     (pix_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		pix_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_stall_due) begin
				long_stall_due = 1'b0;
				pix_ch.ready <= 1'b0;
				repeat (LONG_STALL_CYCLES) @(posedge clk);
			end
			pix_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic apb_write(reg_idx_t idx, int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic end_apb();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic program_format(int phase, int width, int height, int padding);
		apb_write(REG_BAYER_PHASE, phase);
		apb_write(REG_IMAGE_WIDTH, width);
		apb_write(REG_IMAGE_HEIGHT, height);
		apb_write(REG_ROW_PADDING, padding);
		end_apb();
	endtask

	task automatic offer_byte(logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			raw_ch.valid <= 1'b0;
			@(posedge clk);
		end
		raw_ch.valid <= 1'b1;
		raw_ch.raw_byte <= b;
		do @(posedge clk); while (!raw_ch.ready);
	endtask

	task automatic send_row(int ncols, int npad);
		logic [7:0] b;
		for (int i = 0; i < ncols + npad; i++) begin
			case ($urandom_range(5))
				0:       b = 8'h00;
				1:       b = 8'hFF;
				default: b = 8'($urandom_range(255));
			endcase
			offer_byte(b);
		end
		pixel_bytes += ncols;
		padding_bytes += npad;
	endtask

	task automatic send_frame(int width, int height, int padding);
		repeat (height) send_row(width, padding);
	endtask

	task automatic drain();
		raw_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [7:0] corner_px [15];
		int         w, h, pad, phase_start;
		corner_px = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hA5,
			8'hFF, 8'h00, 8'hFF, 8'h00, 8'h5A,
			8'h80, 8'h7F, 8'h01, 8'hFE, 8'h00};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		raw_ch.valid = 1'b0;
		raw_ch.raw_byte = '0;
		long_stall_due = 1'b0;
		pixel_bytes = 0;
		padding_bytes = 0;
		send_idle_pct = 16;
		recv_idle_pct = 71;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Checkerboard extremes with one padding byte per row, then clamped sizes.
		program_format(0, 4, 3, 1);
		foreach (corner_px[i]) offer_byte(corner_px[i]);
		pixel_bytes += 12;
		padding_bytes += 3;
		drain();
		program_format(3, 0, 1, 0);
		send_frame(2, 2, 0);
		drain();
		program_format(2, 3, 2, 0);
		send_frame(3, 2, 0);

		for (int stage = 0; stage < 3; stage++) begin
			case (stage)
				0: begin
					send_idle_pct = 16;
					recv_idle_pct = 71;
				end
				1: begin
					send_idle_pct = 71;
					recv_idle_pct = 16;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			phase_start = pixel_bytes;
			if (stage == 0) begin
				drain();
				program_format($urandom_range(3), 6, 2, 0);
				long_stall_due = 1'b1;
				send_frame(6, 2, 0);
			end
			while (pixel_bytes - phase_start < RANDOM_PER_PHASE) begin
				w = $urandom_range(5, 2);
				h = $urandom_range(3, 2);
				pad = ($urandom_range(2) == 0) ? 0 : $urandom_range(3, 1);
				drain();
				program_format($urandom_range(3), w, h, pad);
				send_frame(w, h, pad);
			end
		end

		// Long padding, then registers changed between rows of a frame.
		drain();
		program_format(1, 2, 2, 6);
		send_frame(2, 2, 6);
		drain();
		program_format(3, 3, 65535, 0);
		send_frame(3, 2, 0);
		drain();
		apb_write(REG_IMAGE_HEIGHT, 2);
		end_apb();
		send_row(3, 0);
		drain();
		program_format(0, 6, 3, 2);
		send_row(6, 2);
		send_row(3, 0);
		drain();
		apb_write(REG_IMAGE_WIDTH, 2);
		end_apb();
		send_row(0, 2);
		send_row(2, 2);
		drain();

		$display("Fed %0d pixel bytes and %0d padding bytes, checked %0d pixels.",
			pixel_bytes, padding_bytes, checked);
		$display("All four Bayer phases, edge mirroring, clamped sizes, mid-frame changes and stalls.");
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
